// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion sampled on the rising clock, quiet while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Implication form of the above.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ===== src/dqf_pkg.sv =====
package dqf_pkg;

   localparam int LABEL_MAX_DEFAULT = 32;
   localparam int QUEUE_DEPTH       = 4;
   localparam int CSR_DATA_WIDTH    = 16;
   localparam int CSR_INDEX_WIDTH   = 3;
   localparam int STEP_WIDTH        = 4;

   localparam logic [7:0] CHAR_END   = 8'h00;
   localparam logic [7:0] CHAR_DOT   = 8'h2E;
   localparam logic [7:0] NAME_LIMIT = 8'd250;

   localparam logic [STEP_WIDTH-1:0] HEADER_LAST = STEP_WIDTH'(11);
   localparam logic [STEP_WIDTH-1:0] TAIL_LAST   = STEP_WIDTH'(4);

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_TRANSACTION_ID = CSR_INDEX_WIDTH'(0);
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_HEADER_FLAGS   = CSR_INDEX_WIDTH'(1);
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_QUERY_TYPE     = CSR_INDEX_WIDTH'(2);
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_QUERY_CLASS    = CSR_INDEX_WIDTH'(3);

   localparam logic [15:0] TRANSACTION_ID_RESET = 16'h1234;
   localparam logic [15:0] HEADER_FLAGS_RESET   = 16'h0100;
   localparam logic [15:0] QUERY_TYPE_RESET     = 16'h0001;
   localparam logic [15:0] QUERY_CLASS_RESET    = 16'h0001;

   typedef enum logic [1:0] {
      CMD_CHAR,
      CMD_DOT,
      CMD_END
   } cmd_kind_type;

   // One classified name character as it travels from front to back.
   typedef struct packed {
      logic         new_name;
      cmd_kind_type kind;
      logic [7:0]   ch;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic valid;
   } queue_status_type;

endpackage

// ===== src/dqf_front.sv =====
module dqf_front
   import dqf_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [7:0]       req_name_char,
   input  queue_status_type q_status,
   output logic             push,
   output cmd_type          push_cmd
);

   logic in_name_ff;
   logic in_name_in;

   assign req_stall = q_status.full;
   assign push      = req_valid && !q_status.full;

   always_comb begin
      push_cmd.new_name = !in_name_ff;
      push_cmd.ch       = req_name_char;
      if (req_name_char == CHAR_END) begin
         push_cmd.kind = CMD_END;
      end else if (req_name_char == CHAR_DOT) begin
         push_cmd.kind = CMD_DOT;
      end else begin
         push_cmd.kind = CMD_CHAR;
      end
   end

   // Any accepted character other than the terminator leaves a name open.
   assign in_name_in = push ? (req_name_char != CHAR_END) : in_name_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_name_ff <= 1'b0;
      end else begin
         in_name_ff <= in_name_in;
      end
   end

endmodule

// ===== src/dqf_queue.sv =====
module dqf_queue
   import dqf_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
)
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  cmd_type          push_cmd,
   input  logic             pop,
   output cmd_type          pop_cmd,
   output queue_status_type q_status
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   cmd_type        entry_ff [DEPTH];
   logic [PW-1:0]  wr_ptr_ff;
   logic [PW-1:0]  wr_ptr_in;
   logic [PW-1:0]  rd_ptr_ff;
   logic [PW-1:0]  rd_ptr_in;
   logic [CW-1:0]  count_ff;
   logic [CW-1:0]  count_in;
   logic           do_push;
   logic           do_pop;

   assign q_status.full  = (count_ff == CW'(DEPTH));
   assign q_status.valid = (count_ff != '0);
   assign pop_cmd        = entry_ff[rd_ptr_ff];

   assign do_push = push && !q_status.full;
   assign do_pop  = pop && q_status.valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== src/dqf_back.sv =====
module dqf_back
   import dqf_pkg::*;
#(
   parameter int LABEL_MAX = LABEL_MAX_DEFAULT
)
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_write_data,
   input  queue_status_type           q_status,
   input  cmd_type                    pop_cmd,
   output logic                       pop,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [7:0]                 rsp_out_byte,
   output logic [7:0]                 rsp_out_position,
   output logic                       rsp_end_of_query,
   output logic                       rsp_too_long
);

   localparam int LCW = $clog2(LABEL_MAX + 1);
   localparam int AW  = (LABEL_MAX > 1) ? $clog2(LABEL_MAX) : 1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_HEADER,
      ST_EXEC,
      ST_LENGTH,
      ST_DATA,
      ST_TAIL
   } state_type;

   state_type             state_ff, state_in;
   cmd_type               cmd_ff, cmd_in;
   logic [STEP_WIDTH-1:0] step_ff, step_in;
   logic [LCW-1:0]        label_count_ff, label_count_in;
   logic [LCW-1:0]        keep_ff, keep_in;
   logic [LCW-1:0]        rd_idx_ff, rd_idx_in;
   logic [7:0]            byte_offset_ff, byte_offset_in;
   logic                  overflow_ff, overflow_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [7:0]            rsp_byte_ff, rsp_byte_in;
   logic [7:0]            rsp_pos_ff, rsp_pos_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic                  rsp_long_ff, rsp_long_in;

   logic [15:0]           transaction_id_ff;
   logic [15:0]           header_flags_ff;
   logic [15:0]           query_type_ff;
   logic [15:0]           query_class_ff;

   logic [7:0]            label_mem [LABEL_MAX];
   logic [7:0]            rd_data_ff;
   logic                  mem_we;

   logic                  can_emit;
   logic                  emit_en;
   logic [7:0]            emit_byte;
   logic                  emit_last;
   logic                  name_done;
   logic [7:0]            avail;
   logic [8:0]            need;
   state_type             after_label;
   logic [7:0]            header_byte;
   logic [7:0]            tail_byte;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_byte     = rsp_byte_ff;
   assign rsp_out_position = rsp_pos_ff;
   assign rsp_end_of_query = rsp_last_ff;
   assign rsp_too_long     = rsp_long_ff;

   assign can_emit    = !rsp_valid_ff || !rsp_stall;
   assign avail       = (byte_offset_ff < NAME_LIMIT) ? NAME_LIMIT - byte_offset_ff : 8'd0;
   assign need        = 9'(label_count_ff) + 9'd1;
   assign after_label = (cmd_ff.kind == CMD_END) ? ST_TAIL : ST_IDLE;

   always_comb begin
      unique case (step_ff)
         4'd0:    header_byte = transaction_id_ff[15:8];
         4'd1:    header_byte = transaction_id_ff[7:0];
         4'd2:    header_byte = header_flags_ff[15:8];
         4'd3:    header_byte = header_flags_ff[7:0];
         4'd5:    header_byte = 8'h01;
         default: header_byte = 8'h00;
      endcase
      unique case (step_ff)
         4'd1:    tail_byte = query_type_ff[15:8];
         4'd2:    tail_byte = query_type_ff[7:0];
         4'd3:    tail_byte = query_class_ff[15:8];
         4'd4:    tail_byte = query_class_ff[7:0];
         default: tail_byte = 8'h00;
      endcase
   end

   always_comb begin
      state_in       = state_ff;
      cmd_in         = cmd_ff;
      step_in        = step_ff;
      label_count_in = label_count_ff;
      keep_in        = keep_ff;
      rd_idx_in      = rd_idx_ff;
      byte_offset_in = byte_offset_ff;
      overflow_in    = overflow_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_byte_in    = rsp_byte_ff;
      rsp_pos_in     = rsp_pos_ff;
      rsp_last_in    = rsp_last_ff;
      rsp_long_in    = rsp_long_ff;
      pop            = 1'b0;
      mem_we         = 1'b0;
      emit_en        = 1'b0;
      emit_byte      = 8'h00;
      emit_last      = 1'b0;
      name_done      = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (q_status.valid) begin
               pop    = 1'b1;
               cmd_in = pop_cmd;
               if (pop_cmd.new_name) begin
                  byte_offset_in = 8'd0;
                  label_count_in = '0;
                  overflow_in    = 1'b0;
                  step_in        = '0;
                  state_in       = ST_HEADER;
               end else begin
                  state_in = ST_EXEC;
               end
            end
         end
         ST_HEADER: begin
            if (can_emit) begin
               emit_en   = 1'b1;
               emit_byte = header_byte;
               step_in   = step_ff + STEP_WIDTH'(1);
               if (step_ff == HEADER_LAST) begin
                  state_in = ST_EXEC;
               end
            end
         end
         ST_EXEC: begin
            if (cmd_ff.kind == CMD_CHAR) begin
               if (label_count_ff < LCW'(LABEL_MAX)) begin
                  mem_we         = 1'b1;
                  label_count_in = label_count_ff + LCW'(1);
               end else begin
                  overflow_in = 1'b1;
               end
               state_in = ST_IDLE;
            end else begin
               label_count_in = '0;
               step_in        = '0;
               rd_idx_in      = '0;
               keep_in        = label_count_ff;
               if (avail == 8'd0) begin
                  // Not even the length byte fits: the label is dropped.
                  overflow_in = 1'b1;
                  state_in    = after_label;
               end else begin
                  if (need > {1'b0, avail}) begin
                     keep_in     = LCW'(avail - 8'd1);
                     overflow_in = 1'b1;
                  end
                  state_in = ST_LENGTH;
               end
            end
         end
         ST_LENGTH: begin
            if (can_emit) begin
               emit_en   = 1'b1;
               emit_byte = 8'(keep_ff);
               state_in  = (keep_ff == '0) ? after_label : ST_DATA;
            end
         end
         ST_DATA: begin
            if (can_emit) begin
               emit_en   = 1'b1;
               emit_byte = rd_data_ff;
               if ((rd_idx_ff + LCW'(1)) == keep_ff) begin
                  state_in = after_label;
               end else begin
                  rd_idx_in = rd_idx_ff + LCW'(1);
               end
            end
         end
         ST_TAIL: begin
            if (can_emit) begin
               emit_en   = 1'b1;
               emit_byte = tail_byte;
               step_in   = step_ff + STEP_WIDTH'(1);
               if (step_ff == TAIL_LAST) begin
                  emit_last = 1'b1;
                  name_done = 1'b1;
                  state_in  = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (emit_en) begin
         rsp_valid_in   = 1'b1;
         rsp_byte_in    = emit_byte;
         rsp_pos_in     = byte_offset_ff;
         rsp_last_in    = emit_last;
         rsp_long_in    = overflow_ff;
         byte_offset_in = byte_offset_ff + 8'd1;
      end
      if (name_done) begin
         byte_offset_in = 8'd0;
         overflow_in    = 1'b0;
         label_count_in = '0;
      end
   end

   // The read address runs one step ahead so rd_data_ff always holds the entry at rd_idx_ff.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         label_mem[label_count_ff[AW-1:0]] <= cmd_ff.ch;
      end
      rd_data_ff <= label_mem[rd_idx_in[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         transaction_id_ff <= TRANSACTION_ID_RESET;
         header_flags_ff   <= HEADER_FLAGS_RESET;
         query_type_ff     <= QUERY_TYPE_RESET;
         query_class_ff    <= QUERY_CLASS_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            REG_TRANSACTION_ID: transaction_id_ff <= csr_write_data;
            REG_HEADER_FLAGS:   header_flags_ff   <= csr_write_data;
            REG_QUERY_TYPE:     query_type_ff     <= csr_write_data;
            REG_QUERY_CLASS:    query_class_ff    <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         step_ff        <= '0;
         label_count_ff <= '0;
         rd_idx_ff      <= '0;
         byte_offset_ff <= 8'd0;
         overflow_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         step_ff        <= step_in;
         label_count_ff <= label_count_in;
         rd_idx_ff      <= rd_idx_in;
         byte_offset_ff <= byte_offset_in;
         overflow_ff    <= overflow_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      cmd_ff      <= cmd_in;
      keep_ff     <= keep_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_pos_ff  <= rsp_pos_in;
      rsp_last_ff <= rsp_last_in;
      rsp_long_ff <= rsp_long_in;
   end

endmodule

// ===== src/dns_query_framer.sv =====
// Turns a dotted host name, one character per item and ended by a zero byte, into the
// bytes of a DNS query: a 12-byte header on the first character of a name, each label as a
// length byte followed by its characters, then the root byte, query type and query class.
// Characters enter a four-entry queue at up to one per cycle while it is not full. The back
// sequencer pops each character and writes an ordinary one into the label store; for a dot
// or the terminator it sends the label's length byte and characters as the output takes
// them. A new name first sends its header, and the terminator ends with the closing bytes.
// Progress is bounded by the single sequencer and the store's one read port. Each message
// byte comes with its offset, a flag on the final byte, and a flag that is set once a label
// exceeded LABEL_MAX characters or the labels ran past the first 250 bytes of the message.
// No pass over the label store follows reset. Configuration writes belong to idle periods.
module dns_query_framer
   import dqf_pkg::*;
#(
   parameter int LABEL_MAX = LABEL_MAX_DEFAULT
)
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [7:0]                 req_name_char,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [7:0]                 rsp_out_byte,
   output logic [7:0]                 rsp_out_position,
   output logic                       rsp_end_of_query,
   output logic                       rsp_too_long,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_write_data
);

   queue_status_type q_status;
   logic             push;
   cmd_type          push_cmd;
   logic             pop;
   cmd_type          pop_cmd;

   dqf_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_name_char (req_name_char),
      .q_status      (q_status),
      .push          (push),
      .push_cmd      (push_cmd)
   );

   dqf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .pop_cmd  (pop_cmd),
      .q_status (q_status)
   );

   dqf_back #(
      .LABEL_MAX (LABEL_MAX)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .q_status         (q_status),
      .pop_cmd          (pop_cmd),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_out_position (rsp_out_position),
      .rsp_end_of_query (rsp_end_of_query),
      .rsp_too_long     (rsp_too_long)
   );

endmodule

// ===== src/dqf_checker.sv =====
`include "assert_macros.svh"

module dqf_checker
(
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_out_byte,
   input logic [7:0] rsp_out_position,
   input logic       rsp_end_of_query,
   input logic       rsp_too_long
);

   // A stalled byte stays on the port unchanged.
   `ASSERT_IMPLY(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      ##1 (rsp_valid && $stable(rsp_out_byte) && $stable(rsp_out_position)
           && $stable(rsp_end_of_query) && $stable(rsp_too_long)),
      "stalled response item changed")

   // The shortest message is a header, an empty label, the root byte and four closing bytes.
   `ASSERT_IMPLY(a_end_min_len, clock, reset, rsp_valid && rsp_end_of_query,
      rsp_out_position >= 8'd16, "message ended before its closing bytes")

   // The first byte of a message opens a fresh name, so neither flag can be up.
   `ASSERT_IMPLY(a_first_clean, clock, reset, rsp_valid && (rsp_out_position == 8'd0),
      !rsp_too_long && !rsp_end_of_query, "first byte carries a stale flag")

   // A message never reaches offset 255.
   `ASSERT_CLK(a_pos_limit, clock, reset, rsp_valid |-> (rsp_out_position != 8'hFF),
      "message offset past its limit")

endmodule

bind dns_query_framer dqf_checker u_checker (.*);

// ===== test/dns_query_framer_tb.sv =====
module dns_query_framer_tb;
   import dqf_pkg::*;

   localparam int LABEL_MAX   = LABEL_MAX_DEFAULT;
   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE      = 40;
   localparam int PHASE_CHARS = 38;

   typedef struct packed {
      logic [7:0] out_byte;
      logic [7:0] out_position;
      logic       end_of_query;
      logic       too_long;
   } query_byte_type;

   // One row of the directed part: a character sent reps times in a row. Where typed is set,
   // final_out is the last byte that the final repetition must produce.
   typedef struct {
      logic [7:0]     name_char;
      int unsigned    reps;
      logic           typed;
      query_byte_type final_out;
   } stim_row_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic [7:0]                 req_name_char = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic [7:0]                 rsp_out_byte;
   logic [7:0]                 rsp_out_position;
   logic                       rsp_end_of_query;
   logic                       rsp_too_long;
   logic                       csr_write_enable = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_write_data = '0;

   // Shadow registers and name state of the predictor.
   logic [15:0] txn_id_reg     = TRANSACTION_ID_RESET;
   logic [15:0] flags_reg      = HEADER_FLAGS_RESET;
   logic [15:0] qtype_reg      = QUERY_TYPE_RESET;
   logic [15:0] qclass_reg     = QUERY_CLASS_RESET;
   logic        name_open      = 1'b0;
   logic [7:0]  label_buf [LABEL_MAX];
   int          label_len      = 0;
   logic [7:0]  next_position  = '0;
   logic        overflow_flag  = 1'b0;

   query_byte_type expected_query_bytes [$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int chars_sent    = 0;
   int mismatches    = 0;
   int cycle_count   = 0;

   stim_row_type stim_table [13] = '{
      '{CHAR_END, 1,   1'b1, {8'h01, 8'd17,  1'b1, 1'b0}},
      '{8'hFF,    1,   1'b1, {8'h00, 8'd11,  1'b0, 1'b0}},
      '{CHAR_DOT, 1,   1'b1, {8'hFF, 8'd13,  1'b0, 1'b0}},
      '{CHAR_DOT, 1,   1'b1, {8'h00, 8'd14,  1'b0, 1'b0}},
      '{8'h01,    1,   1'b0, '0},
      '{8'h2F,    1,   1'b0, '0},
      '{8'h2D,    1,   1'b0, '0},
      '{8'h7F,    1,   1'b0, '0},
      '{8'h80,    1,   1'b0, '0},
      '{CHAR_END, 1,   1'b1, {8'h01, 8'd25,  1'b1, 1'b0}},
      '{8'h41,    34,  1'b0, '0},
      '{CHAR_DOT, 1,   1'b1, {8'h41, 8'd44,  1'b0, 1'b1}},
      '{CHAR_END, 1,   1'b1, {8'h01, 8'd50,  1'b1, 1'b1}}
   };

   dns_query_framer #(
      .LABEL_MAX(LABEL_MAX)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_name_char(req_name_char),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_out_byte(rsp_out_byte),
      .rsp_out_position(rsp_out_position),
      .rsp_end_of_query(rsp_end_of_query),
      .rsp_too_long(rsp_too_long),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function void emit_query_byte(input logic [7:0] value, input logic is_end);
      expected_query_bytes.push_back({value, next_position, is_end, overflow_flag});
      next_position = next_position + 8'd1;
   endfunction

   // Sends the buffered label as a length byte and its characters, cut short where the
   // name area of the message runs out.
   function void flush_label();
      int room;
      int keep;
      room = (next_position < NAME_LIMIT) ? int'(NAME_LIMIT) - int'(next_position) : 0;
      keep = label_len;
      if (room == 0) begin
         overflow_flag = 1'b1;
      end else begin
         if (keep + 1 > room) begin
            keep = room - 1;
            overflow_flag = 1'b1;
         end
         emit_query_byte(8'(keep), 1'b0);
         for (int i = 0; i < keep; i++) begin
            emit_query_byte(label_buf[i], 1'b0);
         end
      end
      label_len = 0;
   endfunction

   function void predict_query_bytes(input logic [7:0] c);
      if (!name_open) begin
         next_position = '0;
         label_len = 0;
         overflow_flag = 1'b0;
         emit_query_byte(txn_id_reg[15:8], 1'b0);
         emit_query_byte(txn_id_reg[7:0], 1'b0);
         emit_query_byte(flags_reg[15:8], 1'b0);
         emit_query_byte(flags_reg[7:0], 1'b0);
         emit_query_byte(8'h00, 1'b0);
         emit_query_byte(8'h01, 1'b0);
         repeat (6) emit_query_byte(8'h00, 1'b0);
         name_open = 1'b1;
      end
      if (c == CHAR_END) begin
         flush_label();
         emit_query_byte(8'h00, 1'b0);
         emit_query_byte(qtype_reg[15:8], 1'b0);
         emit_query_byte(qtype_reg[7:0], 1'b0);
         emit_query_byte(qclass_reg[15:8], 1'b0);
         emit_query_byte(qclass_reg[7:0], 1'b1);
         name_open = 1'b0;
         label_len = 0;
         next_position = '0;
         overflow_flag = 1'b0;
      end else if (c == CHAR_DOT) begin
         flush_label();
      end else if (label_len < LABEL_MAX) begin
         label_buf[label_len] = c;
         label_len++;
      end else begin
         overflow_flag = 1'b1;
      end
   endfunction

   // Called at a falling edge; returns at the falling edge after the item was taken.
   task automatic push_char(input logic [7:0] c);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_name_char <= c;
      do @(posedge clock); while (req_stall);
      predict_query_bytes(c);
      chars_sent++;
      @(negedge clock);
   endtask

   function automatic logic [7:0] random_label_char();
      logic [7:0] c;
      do c = 8'($urandom_range(1, 255)); while (c == CHAR_DOT);
      return c;
   endfunction

   // Mostly well-formed names with random content; one in ten is raw noise.
   task automatic send_random_name();
      int labels;
      int len;
      if ($urandom_range(9) == 0) begin
         len = $urandom_range(1, 12);
         repeat (len) push_char(8'($urandom_range(1, 255)));
      end else begin
         labels = $urandom_range(1, 4);
         for (int l = 0; l < labels; l++) begin
            if (l != 0) begin
               push_char(CHAR_DOT);
            end
            len = ($urandom_range(9) == 0) ? $urandom_range(28, LABEL_MAX + 4)
                                            : $urandom_range(0, 6);
            repeat (len) push_char(random_label_char());
         end
      end
      push_char(CHAR_END);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] idx, input logic [15:0] value);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      @(posedge clock);
      case (idx)
         REG_TRANSACTION_ID: txn_id_reg = value;
         REG_HEADER_FLAGS:   flags_reg = value;
         REG_QUERY_TYPE:     qtype_reg = value;
         REG_QUERY_CLASS:    qclass_reg = value;
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic load_registers(input logic [15:0] id_v, flags_v, type_v, class_v);
      write_reg(REG_TRANSACTION_ID, id_v);
      write_reg(REG_HEADER_FLAGS, flags_v);
      write_reg(REG_QUERY_TYPE, type_v);
      write_reg(REG_QUERY_CLASS, class_v);
      // An index past the last register must leave every register alone.
      write_reg(CSR_INDEX_WIDTH'($urandom_range(REG_QUERY_CLASS + 1, (1 << CSR_INDEX_WIDTH) - 1)),
                16'($urandom_range(0, 65535)));
      csr_write_enable <= 1'b0;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_query_bytes.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic run_random_phase();
      int start;
      start = chars_sent;
      while (chars_sent - start < PHASE_CHARS) send_random_name();
      wait_drained();
   endtask

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   always @(posedge clock) begin : check_output
      query_byte_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_query_bytes.size() == 0) begin
            $error("unexpected item: out_byte %0h out_position %0d", rsp_out_byte,
                   rsp_out_position);
            mismatches++;
         end else begin
            want = expected_query_bytes.pop_front();
            if (rsp_out_byte !== want.out_byte) begin
               $error("out_byte: expected %0h, got %0h", want.out_byte, rsp_out_byte);
               mismatches++;
            end
            if (rsp_out_position !== want.out_position) begin
               $error("out_position: expected %0d, got %0d", want.out_position,
                      rsp_out_position);
               mismatches++;
            end
            if (rsp_end_of_query !== want.end_of_query) begin
               $error("end_of_query: expected %0b, got %0b", want.end_of_query,
                      rsp_end_of_query);
               mismatches++;
            end
            if (rsp_too_long !== want.too_long) begin
               $error("too_long: expected %0b, got %0b", want.too_long, rsp_too_long);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_idle_pct = 33;
      recv_idle_pct = 69;
      foreach (stim_table[r]) begin
         for (int k = 0; k < stim_table[r].reps; k++) begin
            push_char(stim_table[r].name_char);
         end
         if (stim_table[r].typed) begin
            expected_query_bytes[expected_query_bytes.size() - 1] = stim_table[r].final_out;
         end
      end
      wait_drained();

      load_registers(16'h0000, 16'h0000, 16'h0000, 16'h0000);
      run_random_phase();

      send_idle_pct = 69;
      recv_idle_pct = 33;
      load_registers(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      run_random_phase();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      load_registers(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                     16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
      run_random_phase();

      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
